/* rtl/error_detect_code_generator_defines.svh */
// Assertion helpers shared by the RTL files of the error detect code generator.
`ifndef ERROR_DETECT_CODE_GENERATOR_DEFINES_SVH
`define ERROR_DETECT_CODE_GENERATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define EDCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define EDCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/edcg_pkg.sv */
`default_nettype none
package edcg_pkg;

  // Method register codes.
  typedef enum logic [2:0] {
    METHOD_BYTE_PARITY = 3'd0,
    METHOD_ROW_PARITY  = 3'd1,
    METHOD_CRC16       = 3'd2,
    METHOD_HAMMING74   = 3'd3,
    METHOD_CSUM        = 3'd4
  } method_t;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // The queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // One or two result words produced by one input word.
  typedef struct packed {
    logic       two;
    logic [7:0] code0;
    logic       last0;
    logic [7:0] code1;
    logic       last1;
  } pair_t;

  // Queue occupancy seen by the front and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Odd number of one bits.
  function automatic logic odd_ones(input logic [7:0] b);
    return ^b;
  endfunction

  // Hamming(7,4) codeword: p1 p2 d0 p4 d1 d2 d3 from bit 0 up, bit 7 zero.
  function automatic logic [7:0] ham_nibble(input logic [3:0] d);
    logic p1;
    logic p2;
    logic p4;
    p1 = d[0] ^ d[1] ^ d[3];
    p2 = d[0] ^ d[2] ^ d[3];
    p4 = d[1] ^ d[2] ^ d[3];
    return {1'b0, d[3], d[2], d[1], p4, d[0], p2, p1};
  endfunction

  // CRC-16-CCITT over one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // One's complement add with end-around carry.
  function automatic logic [15:0] csum_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage
`default_nettype wire

/* rtl/edcg_front.sv */
`default_nettype none
module edcg_front #(
  parameter int ROW_LENGTH = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_data_byte,
  input  wire                 in_last_byte,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_wdata,
  input  edcg_pkg::queue_stat_t q_stat,
  output logic                push,
  output edcg_pkg::pair_t     push_pair
);

  localparam int COL_W = (ROW_LENGTH > 1) ? $clog2(ROW_LENGTH) : 1;

  logic [2:0]       method_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             odd_r, odd_nxt;
  logic [7:0]       row_r, row_nxt;
  logic [7:0]       all_r, all_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic             accept;
  logic             has_res;
  logic [7:0]       row_x;
  logic [7:0]       all_x;
  logic             row_end;
  logic [15:0]      crc_x;
  logic [15:0]      sum_x;
  logic [15:0]      csum_word;
  logic [15:0]      csum_c;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_res;

  // Method register; the user must write it only while the block is idle, the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= edcg_pkg::METHOD_CRC16;
    end else if (cfg_we) begin
      method_r <= cfg_wdata;
    end
  end

  // Per-method arithmetic on the incoming word.
  always_comb begin
    row_x     = row_r ^ in_data_byte;
    row_end   = (col_r == COL_W'(ROW_LENGTH - 1)) || in_last_byte;
    all_x     = all_r ^ row_x;
    crc_x     = edcg_pkg::crc_byte(crc_r, in_data_byte);
    csum_word = odd_r ? {held_r, in_data_byte} : {in_data_byte, 8'h00};
    sum_x     = (odd_r || in_last_byte) ? edcg_pkg::csum_add(sum_r, csum_word) : sum_r;
    csum_c    = ~sum_x;
  end

  // Classify the word: results to queue and next message state.
  always_comb begin
    crc_nxt   = crc_r;
    sum_nxt   = sum_r;
    held_nxt  = held_r;
    odd_nxt   = odd_r;
    row_nxt   = row_r;
    all_nxt   = all_r;
    col_nxt   = col_r;
    has_res   = 1'b0;
    push_pair = '0;
    unique case (method_r)
      edcg_pkg::METHOD_BYTE_PARITY: begin
        has_res         = 1'b1;
        push_pair.code0 = {7'd0, edcg_pkg::odd_ones(in_data_byte)};
        push_pair.last0 = in_last_byte;
      end
      edcg_pkg::METHOD_ROW_PARITY: begin
        if (row_end) begin
          has_res         = 1'b1;
          push_pair.code0 = row_x;
          push_pair.two   = in_last_byte;
          push_pair.code1 = all_x;
          push_pair.last1 = 1'b1;
          row_nxt         = 8'h00;
          all_nxt         = all_x;
          col_nxt         = '0;
        end else begin
          row_nxt = row_x;
          col_nxt = col_r + COL_W'(1);
        end
      end
      edcg_pkg::METHOD_CRC16: begin
        crc_nxt         = crc_x;
        has_res         = in_last_byte;
        push_pair.two   = 1'b1;
        push_pair.code0 = crc_x[15:8];
        push_pair.code1 = crc_x[7:0];
        push_pair.last1 = 1'b1;
      end
      edcg_pkg::METHOD_HAMMING74: begin
        has_res         = 1'b1;
        push_pair.two   = 1'b1;
        push_pair.code0 = edcg_pkg::ham_nibble(in_data_byte[7:4]);
        push_pair.code1 = edcg_pkg::ham_nibble(in_data_byte[3:0]);
        push_pair.last1 = in_last_byte;
      end
      edcg_pkg::METHOD_CSUM: begin
        sum_nxt         = sum_x;
        odd_nxt         = !odd_r;
        held_nxt        = odd_r ? held_r : in_data_byte;
        has_res         = in_last_byte;
        push_pair.two   = 1'b1;
        push_pair.code0 = csum_c[15:8];
        push_pair.code1 = csum_c[7:0];
        push_pair.last1 = 1'b1;
      end
      default: begin
        // Unused method codes ignore the word and keep all state.
      end
    endcase
  end

  // Message state; a valid method clears all of it at message end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= edcg_pkg::CRC_INIT;
      sum_r  <= 16'h0000;
      held_r <= 8'h00;
      odd_r  <= 1'b0;
      row_r  <= 8'h00;
      all_r  <= 8'h00;
      col_r  <= '0;
    end else if (accept) begin
      if (in_last_byte && method_r <= edcg_pkg::METHOD_CSUM) begin
        crc_r  <= edcg_pkg::CRC_INIT;
        sum_r  <= 16'h0000;
        held_r <= 8'h00;
        odd_r  <= 1'b0;
        row_r  <= 8'h00;
        all_r  <= 8'h00;
        col_r  <= '0;
      end else begin
        crc_r  <= crc_nxt;
        sum_r  <= sum_nxt;
        held_r <= held_nxt;
        odd_r  <= odd_nxt;
        row_r  <= row_nxt;
        all_r  <= all_nxt;
        col_r  <= col_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/edcg_queue.sv */
`default_nettype none
`include "error_detect_code_generator_defines.svh"
module edcg_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  edcg_pkg::pair_t       push_pair,
  input  wire                   pop,
  output edcg_pkg::pair_t       pop_pair,
  output edcg_pkg::queue_stat_t q_stat
);

  edcg_pkg::pair_t                slot_r [edcg_pkg::QUEUE_DEPTH];
  logic [edcg_pkg::QUEUE_AW-1:0]  wr_ptr_r;
  logic [edcg_pkg::QUEUE_AW-1:0]  rd_ptr_r;
  logic [edcg_pkg::QUEUE_AW:0]    count_r;

  assign q_stat.full  = (count_r == (edcg_pkg::QUEUE_AW + 1)'(edcg_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_pair     = slot_r[rd_ptr_r];

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_pair;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + edcg_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + edcg_pkg::QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (edcg_pkg::QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (edcg_pkg::QUEUE_AW + 1)'(1);
      end
    end
  end

  `EDCG_ASSERT(a_no_push_full, (push |-> !q_stat.full), "push into a full queue")
  `EDCG_ASSERT(a_no_pop_empty, (pop |-> !q_stat.empty), "pop from an empty queue")
  `EDCG_ASSERT(a_count_bound, (count_r <= (edcg_pkg::QUEUE_AW + 1)'(edcg_pkg::QUEUE_DEPTH)), "queue count beyond depth")

endmodule
`default_nettype wire

/* rtl/edcg_back.sv */
`default_nettype none
`include "error_detect_code_generator_defines.svh"
module edcg_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  edcg_pkg::queue_stat_t q_stat,
  input  edcg_pkg::pair_t       pop_pair,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_code_byte,
  output logic                  out_code_last
);

  logic       out_valid_r;
  logic [7:0] out_code_r;
  logic       out_last_r;
  logic       sec_valid_r;
  logic [7:0] sec_code_r;
  logic       sec_last_r;
  logic       load;

  // The output register may take a new word when it is empty or being taken.
  assign load = !out_valid_r || out_ready;
  assign pop  = load && !sec_valid_r && !q_stat.empty;

  assign out_valid     = out_valid_r;
  assign out_code_byte = out_code_r;
  assign out_code_last = out_last_r;

  // Control: output valid and the pending second word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (load) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else begin
        out_valid_r <= !q_stat.empty;
        sec_valid_r <= !q_stat.empty && pop_pair.two;
      end
    end
  end

  // Payload: the first word goes out, the second waits one transfer.
  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid_r) begin
        out_code_r <= sec_code_r;
        out_last_r <= sec_last_r;
      end else begin
        out_code_r <= pop_pair.code0;
        out_last_r <= pop_pair.last0;
        sec_code_r <= pop_pair.code1;
        sec_last_r <= pop_pair.last1;
      end
    end
  end

  `EDCG_ASSERT(a_sec_behind_out, (sec_valid_r |-> out_valid_r), "second word without a first")
  `EDCG_ASSERT_ALWAYS(a_reset_idle, (!rst_n |=> !out_valid_r && !sec_valid_r), "output not idle after reset")

endmodule
`default_nettype wire

/* rtl/error_detect_code_generator.sv */
// Error detect code generator: takes message bytes, with in_last_byte on the final one, and
// emits control bytes by the method register (0 byte parity, 1 row parity over ROW_LENGTH
// bytes, 2 CRC-16-CCITT, 3 Hamming(7,4), 4 Internet checksum); unused codes 5 to 7 drop the
// byte. A front end takes one byte per cycle whenever its two-entry queue has room and
// computes that byte's control bytes in the same cycle; a back end sends them out one per
// cycle through an output register while the receiver is ready. The single output word per
// cycle bounds the sustained input rate: the input keeps pace with methods that give at most
// one control byte per input byte, but not with Hamming(7,4) or with message ends that give
// two bytes. Write the method only while the block is idle.
`default_nettype none
module error_detect_code_generator #(
  parameter int ROW_LENGTH = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_data_byte,
  input  wire        in_last_byte,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_code_byte,
  output logic       out_code_last,
  input  wire        cfg_we,
  input  wire  [2:0] cfg_wdata
);

  edcg_pkg::queue_stat_t q_stat;
  edcg_pkg::pair_t       push_pair;
  edcg_pkg::pair_t       pop_pair;
  logic                  push;
  logic                  pop;

  // Front end: accepts and classifies bytes.
  edcg_front #(
    .ROW_LENGTH(ROW_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_stat      (q_stat),
    .push        (push),
    .push_pair   (push_pair)
  );

  // Queue between the two ends.
  edcg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pair(push_pair),
    .pop      (pop),
    .pop_pair (pop_pair),
    .q_stat   (q_stat)
  );

  // Back end: one control byte per cycle while the receiver is ready.
  edcg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .pop_pair     (pop_pair),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_code_byte(out_code_byte),
    .out_code_last(out_code_last)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;

  localparam int ROW_LENGTH     = 8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;

  // Method codes that the block ignores.
  localparam logic [2:0] METHOD_RSVD_LO  = 3'd5;
  localparam logic [2:0] METHOD_RSVD_MID = 3'd6;
  localparam logic [2:0] METHOD_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_word_t;

  // Predicts the control words of each accepted message word and checks the results.
  class code_scoreboard;
    logic [2:0]  method;
    logic [15:0] crc_acc;
    logic [15:0] sum_acc;
    logic [7:0]  held_hi;
    logic        odd_phase;
    logic [7:0]  row_acc;
    logic [7:0]  rows_acc;
    int          row_count;
    code_word_t  expected_codes[$];
    int          failures;

    function new();
      method   = edcg_pkg::METHOD_CRC16;
      failures = 0;
      clear_message();
    endfunction

    function void clear_message();
      crc_acc   = edcg_pkg::CRC_INIT;
      sum_acc   = 16'h0000;
      held_hi   = 8'h00;
      odd_phase = 1'b0;
      row_acc   = 8'h00;
      rows_acc  = 8'h00;
      row_count = 0;
    endfunction

    function void set_method(logic [2:0] m);
      method = m;
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction

    function void push_code(logic [7:0] c, logic l);
      code_word_t w;
      w.code = c;
      w.last = l;
      expected_codes.push_back(w);
    endfunction

    // Hamming(7,4) codeword of one nibble, parity bits at positions 0, 1 and 3.
    function logic [7:0] hamming_word(logic [3:0] n);
      logic [7:0] w;
      w    = 8'h00;
      w[0] = n[0] ^ n[1] ^ n[3];
      w[1] = n[0] ^ n[2] ^ n[3];
      w[2] = n[0];
      w[3] = n[1] ^ n[2] ^ n[3];
      w[4] = n[1];
      w[5] = n[2];
      w[6] = n[3];
      return w;
    endfunction

    // One's complement sum with the carry folded back in.
    function void add_sum_word(logic [15:0] w);
      logic [16:0] t;
      t = {1'b0, sum_acc} + {1'b0, w};
      if (t[16]) begin
        sum_acc = t[15:0] + 16'd1;
      end else begin
        sum_acc = t[15:0];
      end
    endfunction

    // Works out the control words caused by one accepted message word.
    function void note_byte(logic [7:0] b, logic l);
      logic        fb;
      logic [15:0] csum;
      case (method)
        edcg_pkg::METHOD_BYTE_PARITY: begin
          push_code({7'd0, ^b}, l);
        end
        edcg_pkg::METHOD_ROW_PARITY: begin
          row_acc   = row_acc ^ b;
          row_count = row_count + 1;
          if (row_count >= ROW_LENGTH || l) begin
            push_code(row_acc, 1'b0);
            rows_acc  = rows_acc ^ row_acc;
            row_acc   = 8'h00;
            row_count = 0;
          end
          if (l) begin
            push_code(rows_acc, 1'b1);
          end
        end
        edcg_pkg::METHOD_CRC16: begin
          // Bit-serial form: feedback is the top bit XOR the next message bit.
          for (int j = 7; j >= 0; j--) begin
            fb      = crc_acc[15] ^ b[j];
            crc_acc = {crc_acc[14:0], 1'b0} ^ (fb ? edcg_pkg::CRC_POLY : 16'h0000);
          end
          if (l) begin
            push_code(crc_acc[15:8], 1'b0);
            push_code(crc_acc[7:0], 1'b1);
          end
        end
        edcg_pkg::METHOD_HAMMING74: begin
          push_code(hamming_word(b[7:4]), 1'b0);
          push_code(hamming_word(b[3:0]), l);
        end
        edcg_pkg::METHOD_CSUM: begin
          if (odd_phase) begin
            add_sum_word({held_hi, b});
            odd_phase = 1'b0;
          end else begin
            held_hi   = b;
            odd_phase = 1'b1;
            // An odd final word is padded with a zero low half.
            if (l) begin
              add_sum_word({b, 8'h00});
            end
          end
          if (l) begin
            csum = ~sum_acc;
            push_code(csum[15:8], 1'b0);
            push_code(csum[7:0], 1'b1);
          end
        end
        default: begin
          return;
        end
      endcase
      if (l) begin
        clear_message();
      end
    endfunction

    function void note_failure(string msg);
      failures = failures + 1;
      if (failures <= REPORT_LIMIT) begin
        $display("%s", msg);
      end
    endfunction

    // Compares one result word with the oldest expected word.
    function void check_code(logic [7:0] c, logic l);
      code_word_t w;
      if (expected_codes.size() == 0) begin
        note_failure($sformatf("unexpected code word %02h last %0d", c, l));
        return;
      end
      w = expected_codes.pop_front();
      if (w.code !== c || w.last !== l) begin
        note_failure($sformatf("code word mismatch: expected %02h last %0d, got %02h last %0d",
                               w.code, w.last, c, l));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_code_byte;
  logic       out_code_last;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  code_scoreboard sb;
  bit idle_on;
  bit hold_request;
  int hold_left;
  int stall_left;
  int quiet_cycles;

  error_detect_code_generator #(
    .ROW_LENGTH(ROW_LENGTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_code_byte(out_code_byte),
    .out_code_last(out_code_last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: note accepted message words, check accepted result words, watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_byte(in_data_byte, in_last_byte);
      end
      if (out_valid && out_ready) begin
        sb.check_code(out_code_byte, out_code_last);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offers one message word, sometimes after a random gap, and waits until it is taken.
  task automatic send_word(logic [7:0] d, logic l);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Waits until every expected word is out, lets the block settle, then writes the method.
  task automatic write_method(logic [2:0] m);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_method(m);
  endtask

  // Random messages under one method; the last message may be left open.
  task automatic run_phase(logic [2:0] m, int n_items, bit open_end, bit long_hold,
                           bit drain_pause);
    int sent;
    int len;
    int r;
    logic [7:0] d;
    logic l;
    write_method(m);
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       len = 1;
        6, 7:    len = ROW_LENGTH * $urandom_range(1, 2);
        8:       len = $urandom_range(10, 24);
        9:       len = $urandom_range(1, 3);
        default: len = $urandom_range(2, 9);
      endcase
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 15);
        d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        l = (k == len - 1);
        if (sent == n_items - 1 && !open_end) begin
          l = 1'b1;
        end
        send_word(d, l);
        sent = sent + 1;
        if (sent == n_items / 2) begin
          if (long_hold) begin
            hold_request = 1'b1;
          end
          // Sender stops until the block has delivered everything.
          if (drain_pause) begin
            in_valid <= 1'b0;
            do @(negedge clk); while (sb.pending() != 0);
          end
        end
        if (sent == n_items || l) begin
          break;
        end
      end
    end
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 3'd0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // CRC from the reset method, single-word messages at both extremes.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);

    write_method(edcg_pkg::METHOD_BYTE_PARITY);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h01, 1'b1);

    write_method(edcg_pkg::METHOD_HAMMING74);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b1);

    // A row that ends on the last word, then a partial final row.
    write_method(edcg_pkg::METHOD_ROW_PARITY);
    for (int k = 0; k < ROW_LENGTH; k++) begin
      send_word(8'(8'h11 * k + 8'h80), (k == ROW_LENGTH - 1));
    end
    send_word(8'h3C, 1'b1);

    // Odd length checksum, then an even one.
    write_method(edcg_pkg::METHOD_CSUM);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h12, 1'b0);
    send_word(8'h34, 1'b1);

    // Unused method drops its words.
    write_method(METHOD_RSVD_HI);
    send_word(8'h5A, 1'b0);
    send_word(8'hC3, 1'b1);

    // Method changed in the middle of a message.
    write_method(edcg_pkg::METHOD_CRC16);
    send_word(8'h31, 1'b0);
    write_method(edcg_pkg::METHOD_CSUM);
    send_word(8'h32, 1'b1);

    run_phase(edcg_pkg::METHOD_BYTE_PARITY, 60, 1'b0, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_ROW_PARITY, 70, 1'b0, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_CRC16, 70, 1'b0, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_HAMMING74, 60, 1'b0, 1'b1, 1'b0);
    run_phase(edcg_pkg::METHOD_CSUM, 60, 1'b0, 1'b0, 1'b1);
    run_phase(METHOD_RSVD_LO, 20, 1'b1, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_ROW_PARITY, 50, 1'b1, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_CRC16, 50, 1'b1, 1'b0, 1'b0);
    run_phase(METHOD_RSVD_MID, 15, 1'b1, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_HAMMING74, 60, 1'b1, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_CSUM, 60, 1'b0, 1'b0, 1'b0);
    run_phase(METHOD_RSVD_HI, 10, 1'b1, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_BYTE_PARITY, 50, 1'b0, 1'b0, 1'b0);

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    run_phase(edcg_pkg::METHOD_CRC16, 50, 1'b0, 1'b0, 1'b0);
    run_phase(edcg_pkg::METHOD_ROW_PARITY, 50, 1'b0, 1'b0, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
